// ----- rtl/particle_cell_list_binner_defines.svh -----
// Assertion macros shared by the binner's checker.
`ifndef PARTICLE_CELL_LIST_BINNER_DEFINES_SVH
`define PARTICLE_CELL_LIST_BINNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCLB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("binner assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCLB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("binner assertion failed");

`endif

// ----- rtl/pclb_pkg.sv -----
// Shared types and constants of the particle cell-list binner.
package pclb_pkg;

    localparam int POS_W      = 20;
    localparam int POS_MAG_W  = 19;
    localparam int CELLS_W    = 5;
    localparam int SUB_W      = 3;
    localparam int SIZE_W     = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int NUMBER_W   = 12;
    localparam int ENTRY_W    = 13;
    localparam int PRED_W     = 13;
    localparam int DIV_STEPS  = POS_MAG_W;
    localparam int DIV_CNT_W  = 5;

    localparam logic [CFG_IDX_W-1:0] REG_CELLS_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUB_DIV   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 2'd3;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CLEAR = 10'b0000000010,
        S_DIV   = 10'b0000000100,
        S_SUB   = 10'b0000001000,
        S_ENTRY = 10'b0000010000,
        S_RDC   = 10'b0000100000,
        S_RDF   = 10'b0001000000,
        S_WRC   = 10'b0010000000,
        S_WRF   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic sub_calc;
        logic entry_calc;
        logic clr_step;
        logic rd_coarse;
        logic rd_fine;
        logic wr_coarse;
        logic wr_fine;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic outside;
        logic dropped;
    } status_t;

endpackage

// ----- rtl/pclb_ram.sv -----
// Generic single-port RAM with registered read data.
module pclb_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/pclb_div.sv -----
// Restoring divider for one coordinate, one quotient bit per step.
module pclb_div (
    input  logic                            clk,
    input  logic                            load,
    input  logic                            step,
    input  logic [pclb_pkg::POS_MAG_W-1:0]  dividend,
    input  logic [pclb_pkg::POS_MAG_W-1:0]  divisor,
    output logic [pclb_pkg::POS_MAG_W-1:0]  quo,
    output logic [pclb_pkg::POS_MAG_W-1:0]  rem
);
    import pclb_pkg::*;

    logic [POS_MAG_W-1:0] quo_reg, quo_next;
    logic [POS_MAG_W-1:0] rem_reg, rem_next;
    logic [POS_MAG_W-1:0] dsr_reg;
    logic [POS_MAG_W:0]   trial;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[POS_MAG_W-1]};
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (load)
        begin
            quo_next = dividend;
            rem_next = '0;
        end
        else if (step)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = POS_MAG_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[POS_MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[POS_MAG_W-1:0];
                quo_next = {quo_reg[POS_MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (load)
        begin
            dsr_reg <= divisor;
        end
    end

    assign quo = quo_reg;
    assign rem = rem_reg;
endmodule

// ----- rtl/pclb_ctrl.sv -----
// Sequencing state machine of the binner.
module pclb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              restart,
    input  pclb_pkg::status_t status,
    output pclb_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done
);
    import pclb_pkg::*;

    state_t               state_reg, state_next;
    logic                 pending_reg, pending_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (restart)
                    begin
                        pending_next = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    pending_next = 1'b0;
                    state_next   = pending_reg ? S_DIV : S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                cmd.sub_calc = 1'b1;
                state_next   = S_ENTRY;
            end
            S_ENTRY:
            begin
                cmd.entry_calc = 1'b1;
                state_next     = status.dropped ? S_DONE : S_RDC;
            end
            S_RDC:
            begin
                cmd.rd_coarse = 1'b1;
                state_next    = S_RDF;
            end
            S_RDF:
            begin
                cmd.rd_fine = 1'b1;
                state_next  = S_WRC;
            end
            S_WRC:
            begin
                cmd.wr_coarse = 1'b1;
                state_next    = status.outside ? S_DONE : S_WRF;
            end
            S_WRF:
            begin
                cmd.wr_fine = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            pending_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
endmodule

// ----- rtl/pclb_dp.sv -----
// Datapath: configuration, binning dividers, entry arithmetic and tail table.
module pclb_dp #(
    parameter int MAX_CELLS_X   = 16,
    parameter int MAX_CELLS_Y   = 16,
    parameter int MAX_SUB_DIV   = 4,
    parameter int MAX_PARTICLES = 4096,
    parameter int CELL_ENTRIES  = 8192
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pclb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pclb_pkg::SIZE_W-1:0]         cfg_data,
    input  logic signed [pclb_pkg::POS_W-1:0]   pos_x,
    input  logic signed [pclb_pkg::POS_W-1:0]   pos_y,
    input  pclb_pkg::cmd_t                      cmd,
    output pclb_pkg::status_t                   status,
    output logic [pclb_pkg::NUMBER_W-1:0]       particle_number,
    output logic [pclb_pkg::ENTRY_W-1:0]        coarse_entry,
    output logic [pclb_pkg::ENTRY_W-1:0]        fine_entry,
    output logic                                outside,
    output logic signed [pclb_pkg::PRED_W-1:0]  coarse_pred,
    output logic signed [pclb_pkg::PRED_W-1:0]  fine_pred,
    output logic                                dropped
);
    import pclb_pkg::*;

    localparam int AW  = $clog2(CELL_ENTRIES);
    localparam int CW  = $clog2(MAX_PARTICLES + 1);
    localparam int PW  = $clog2(MAX_PARTICLES) + 1;
    localparam int NXW = $clog2(MAX_CELLS_X + 1);
    localparam int NYW = $clog2(MAX_CELLS_Y + 1);
    localparam int MW  = $clog2(MAX_SUB_DIV + 1);
    localparam int C3W = $clog2(MAX_SUB_DIV + 2);
    localparam int C2W = $clog2((MAX_SUB_DIV + 1) * (MAX_SUB_DIV + 1) + 1);
    localparam int C1W = $clog2((MAX_SUB_DIV + 1) * (MAX_SUB_DIV + 1) * (MAX_CELLS_Y + 1) + 1);
    localparam int EXW = C1W + NXW + 2;
    localparam int RSW = POS_MAG_W + MW;

    logic [CELLS_W-1:0] cells_x_reg, cells_y_reg;
    logic [SUB_W-1:0]   sub_div_reg;
    logic [SIZE_W-1:0]  cell_size_reg;

    logic [NXW-1:0]       cx, cx_reg;
    logic [NYW-1:0]       cy, cy_reg;
    logic [MW-1:0]        s, s_reg;
    logic [SIZE_W-1:0]    cs, cs_reg;
    logic [C3W-1:0]       c3_reg;
    logic [C2W-1:0]       c2_reg;
    logic [C1W-1:0]       c1_reg;
    logic                 neg_reg;

    logic [POS_MAG_W-1:0] qx, qy, rx, ry;
    logic [RSW-1:0]       rsx, rsy, kcs;
    logic [MW-1:0]        mx, my;
    logic                 out_now;

    logic [NXW-1:0]       nx_reg;
    logic [NYW-1:0]       ny_reg;
    logic [MW-1:0]        mx_reg, my_reg;
    logic                 out_reg;
    logic [EXW-1:0]       base, ce_full, fe_full;
    logic [AW-1:0]        ce_reg, fe_reg;

    logic [CW-1:0]        count_reg;
    logic [AW-1:0]        clr_addr_reg;
    logic [PW-1:0]        tail_c_reg, tail_f_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [PW-1:0]        ram_wdata, ram_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_x_reg   <= CELLS_W'(16);
            cells_y_reg   <= CELLS_W'(16);
            sub_div_reg   <= SUB_W'(2);
            cell_size_reg <= SIZE_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CELLS_X:   cells_x_reg   <= cfg_data[CELLS_W-1:0];
                REG_CELLS_Y:   cells_y_reg   <= cfg_data[CELLS_W-1:0];
                REG_SUB_DIV:   sub_div_reg   <= cfg_data[SUB_W-1:0];
                REG_CELL_SIZE: cell_size_reg <= cfg_data;
                default:       cells_x_reg   <= cells_x_reg;
            endcase
        end
    end

    // Out-of-range register values saturate into the supported range.
    always_comb
    begin
        if (cells_x_reg == '0)
            cx = NXW'(1);
        else if (int'(cells_x_reg) > MAX_CELLS_X)
            cx = NXW'(MAX_CELLS_X);
        else
            cx = NXW'(cells_x_reg);
        if (cells_y_reg == '0)
            cy = NYW'(1);
        else if (int'(cells_y_reg) > MAX_CELLS_Y)
            cy = NYW'(MAX_CELLS_Y);
        else
            cy = NYW'(cells_y_reg);
        if (sub_div_reg == '0)
            s = MW'(1);
        else if (int'(sub_div_reg) > MAX_SUB_DIV)
            s = MW'(MAX_SUB_DIV);
        else
            s = MW'(sub_div_reg);
        cs = (cell_size_reg == '0) ? SIZE_W'(1) : cell_size_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg  <= cx;
            cy_reg  <= cy;
            s_reg   <= s;
            cs_reg  <= cs;
            c3_reg  <= C3W'(s) + C3W'(1);
            c2_reg  <= C2W'((C2W'(s) + C2W'(1)) * (C2W'(s) + C2W'(1)));
            neg_reg <= pos_x[POS_W-1] | pos_y[POS_W-1];
        end
    end

    pclb_div u_div_x (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.div_step),
        .dividend (pos_x[POS_MAG_W-1:0]),
        .divisor  (cs),
        .quo      (qx),
        .rem      (rx)
    );

    pclb_div u_div_y (
        .clk      (clk),
        .load     (cmd.load),
        .step     (cmd.div_step),
        .dividend (pos_y[POS_MAG_W-1:0]),
        .divisor  (cs),
        .quo      (qy),
        .rem      (ry)
    );

    // The sub-cell index is the number of multiples of the cell size that the
    // remainder times sub_div reaches.
    always_comb
    begin
        rsx = RSW'(rx) * RSW'(s_reg);
        rsy = RSW'(ry) * RSW'(s_reg);
        mx  = '0;
        my  = '0;
        kcs = '0;
        for (int k = 1; k < MAX_SUB_DIV; k++)
        begin
            kcs = RSW'(cs_reg) * RSW'(k);
            if (MW'(k) < s_reg && rsx >= kcs)
                mx = mx + MW'(1);
            if (MW'(k) < s_reg && rsy >= kcs)
                my = my + MW'(1);
        end
        out_now = neg_reg || (qx >= POS_MAG_W'(cx_reg)) || (qy >= POS_MAG_W'(cy_reg));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sub_calc)
        begin
            c1_reg  <= C1W'(C1W'(c2_reg) * (C1W'(cy_reg) + C1W'(1)));
            out_reg <= out_now;
            nx_reg  <= out_now ? cx_reg : qx[NXW-1:0];
            ny_reg  <= out_now ? cy_reg : qy[NYW-1:0];
            mx_reg  <= out_now ? s_reg : mx;
            my_reg  <= out_now ? s_reg : my;
        end
    end

    // The table depth is a power of two, so the wrap is a truncation.
    always_comb
    begin
        base    = EXW'(c1_reg) * EXW'(nx_reg) + EXW'(c2_reg) * EXW'(ny_reg);
        ce_full = base + EXW'(c3_reg) * EXW'(s_reg) + EXW'(s_reg);
        fe_full = base + EXW'(c3_reg) * EXW'(mx_reg) + EXW'(my_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.entry_calc)
        begin
            ce_reg <= ce_full[AW-1:0];
            fe_reg <= out_reg ? ce_full[AW-1:0] : fe_full[AW-1:0];
        end
        if (cmd.rd_fine)
            tail_c_reg <= ram_rdata;
        if (cmd.wr_coarse)
            tail_f_reg <= ram_rdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                count_reg    <= '0;
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            else if (cmd.finish && !dropped)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Only the tail of each list is observable, so only tails are stored.
    always_comb
    begin
        ram_we    = cmd.clr_step | cmd.wr_coarse | cmd.wr_fine;
        ram_wdata = cmd.clr_step ? '1 : PW'(count_reg);
        if (cmd.clr_step)
            ram_addr = clr_addr_reg;
        else if (cmd.rd_coarse || cmd.wr_coarse)
            ram_addr = ce_reg;
        else
            ram_addr = fe_reg;
    end

    pclb_ram #(
        .WIDTH (PW),
        .DEPTH (CELL_ENTRIES)
    ) u_tail_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign dropped         = (int'(count_reg) >= MAX_PARTICLES);
    assign outside         = out_reg;
    assign particle_number = dropped ? '0 : NUMBER_W'(count_reg);
    assign coarse_entry    = ENTRY_W'(ce_reg);
    assign fine_entry      = ENTRY_W'(fe_reg);
    assign coarse_pred     = dropped ? '1 : PRED_W'($signed(tail_c_reg));
    assign fine_pred       = (dropped || out_reg) ? '1 : PRED_W'($signed(tail_f_reg));

    assign status.clr_last = &clr_addr_reg;
    assign status.outside  = out_reg;
    assign status.dropped  = dropped;
endmodule

// ----- rtl/particle_cell_list_binner.sv -----
// Top level of the particle cell-list binner.
// One particle is taken when start is high and busy is low; its result
// appears on the result ports with done high for exactly one cycle, and
// the receiver cannot stall it. A particle outside the grid skips the fine
// list write, and a dropped particle skips all list access. The time to a
// result is set by the 19-step restoring divider, one sub-cell step, one
// entry step, and the read and write of two list tails through the single
// port of the tail table. Busy falls in the cycle after the result, so the
// next particle can be taken as soon as busy is low. After reset, and
// before a particle with restart set, the block sweeps the whole tail
// table one entry a cycle, with busy high. Configuration writes are taken
// at any time but are meant to be made while busy is low.
module particle_cell_list_binner #(
    parameter int MAX_CELLS_X   = 16,
    parameter int MAX_CELLS_Y   = 16,
    parameter int MAX_SUB_DIV   = 4,
    parameter int MAX_PARTICLES = 4096,
    parameter int CELL_ENTRIES  = 8192
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pclb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pclb_pkg::SIZE_W-1:0]         cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic                                restart,
    input  logic signed [pclb_pkg::POS_W-1:0]   pos_x,
    input  logic signed [pclb_pkg::POS_W-1:0]   pos_y,
    output logic                                done,
    output logic [pclb_pkg::NUMBER_W-1:0]       particle_number,
    output logic [pclb_pkg::ENTRY_W-1:0]        coarse_entry,
    output logic [pclb_pkg::ENTRY_W-1:0]        fine_entry,
    output logic                                outside,
    output logic signed [pclb_pkg::PRED_W-1:0]  coarse_pred,
    output logic signed [pclb_pkg::PRED_W-1:0]  fine_pred,
    output logic                                dropped
);
    import pclb_pkg::*;

    cmd_t    cmd;
    status_t status;

    pclb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .restart (restart),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done)
    );

    pclb_dp #(
        .MAX_CELLS_X   (MAX_CELLS_X),
        .MAX_CELLS_Y   (MAX_CELLS_Y),
        .MAX_SUB_DIV   (MAX_SUB_DIV),
        .MAX_PARTICLES (MAX_PARTICLES),
        .CELL_ENTRIES  (CELL_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .cmd             (cmd),
        .status          (status),
        .particle_number (particle_number),
        .coarse_entry    (coarse_entry),
        .fine_entry      (fine_entry),
        .outside         (outside),
        .coarse_pred     (coarse_pred),
        .fine_pred       (fine_pred),
        .dropped         (dropped)
    );
endmodule

// ----- rtl/pclb_checker.sv -----
// Port-level checker of the binner and its bind.
module pclb_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic [pclb_pkg::ENTRY_W-1:0]        coarse_entry,
    input logic [pclb_pkg::ENTRY_W-1:0]        fine_entry,
    input logic                                outside,
    input logic signed [pclb_pkg::PRED_W-1:0]  coarse_pred,
    input logic signed [pclb_pkg::PRED_W-1:0]  fine_pred,
    input logic                                dropped
);
    `include "particle_cell_list_binner_defines.svh"

    `PCLB_ASSERT_NEXT(a_take_busy, start && !busy, busy)
    `PCLB_ASSERT_NEXT(a_done_single, done, !done && !busy)
    `PCLB_ASSERT_NOW(a_done_busy, done, busy)
    `PCLB_ASSERT_NOW(a_out_same, done && outside, fine_entry == coarse_entry && fine_pred == '1)
    `PCLB_ASSERT_NOW(a_drop_none, done && dropped, coarse_pred == '1 && fine_pred == '1)
endmodule

bind particle_cell_list_binner pclb_checker u_pclb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .coarse_entry (coarse_entry),
    .fine_entry   (fine_entry),
    .outside      (outside),
    .coarse_pred  (coarse_pred),
    .fine_pred    (fine_pred),
    .dropped      (dropped)
);

// ----- sim/particle_cell_list_binner_tb.sv -----
// Self-checking testbench for the particle cell-list binner.
`timescale 1ns / 1ps
module particle_cell_list_binner_tb;
    import pclb_pkg::*;

    localparam int MAX_PARTS = 4096;
    localparam int ENTRIES   = 8192;
    localparam int CMAX      = 16;
    localparam int SMAX      = 4;
    localparam int LIMIT     = 3_000_000;
    localparam logic [PRED_W-1:0] NO_PRED = '1;

    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic [ENTRY_W-1:0]  ce;
        logic [ENTRY_W-1:0]  fe;
        logic                outside;
        logic [PRED_W-1:0]   cpred;
        logic [PRED_W-1:0]   fpred;
        logic                dropped;
    } bin_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_CELLS_X;
    logic [SIZE_W-1:0]     cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  restart = 1'b0;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic                  done;
    logic [NUMBER_W-1:0]   particle_number;
    logic [ENTRY_W-1:0]    coarse_entry;
    logic [ENTRY_W-1:0]    fine_entry;
    logic                  outside;
    logic signed [PRED_W-1:0] coarse_pred;
    logic signed [PRED_W-1:0] fine_pred;
    logic                  dropped;

    // Shadow of the configuration and of the list tails.
    logic [CELLS_W-1:0] sh_cells_x = 5'd16;
    logic [CELLS_W-1:0] sh_cells_y = 5'd16;
    logic [SUB_W-1:0]   sh_sub_div = 3'd2;
    logic [SIZE_W-1:0]  sh_cell_size = 19'd256;
    int                 list_tail [ENTRIES];
    int                 particles_held = 0;

    bin_t pending_bins [$];
    int   errors = 0;
    int   cycles = 0;

    particle_cell_list_binner dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .restart(restart),
        .pos_x(pos_x), .pos_y(pos_y), .done(done),
        .particle_number(particle_number), .coarse_entry(coarse_entry),
        .fine_entry(fine_entry), .outside(outside), .coarse_pred(coarse_pred),
        .fine_pred(fine_pred), .dropped(dropped)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int effective_cx();
        return sh_cells_x < 1 ? 1 : (sh_cells_x > CMAX ? CMAX : int'(sh_cells_x));
    endfunction

    function automatic int effective_cy();
        return sh_cells_y < 1 ? 1 : (sh_cells_y > CMAX ? CMAX : int'(sh_cells_y));
    endfunction

    function automatic int effective_sub();
        return sh_sub_div < 1 ? 1 : (sh_sub_div > SMAX ? SMAX : int'(sh_sub_div));
    endfunction

    function automatic int effective_size();
        return sh_cell_size == 0 ? 1 : int'(sh_cell_size);
    endfunction

    function automatic void clear_lists();
        foreach (list_tail[i])
            list_tail[i] = -1;
        particles_held = 0;
    endfunction

    // Bins a particle, lists it unless dropped, and returns the result.
    function automatic bin_t bin_particle(logic rs, logic [POS_W-1:0] px,
                                          logic [POS_W-1:0] py);
        int cx, cy, s, cs, nx, ny, mx, my, ce, fe;
        longint c3, c2, c1;
        logic out_f;
        bin_t r;
        cx = effective_cx();
        cy = effective_cy();
        s = effective_sub();
        cs = effective_size();
        r = '0;
        out_f = 1'b0;
        mx = 0;
        my = 0;
        if (rs)
            clear_lists();
        nx = int'(px[POS_W-2:0]) / cs;
        ny = int'(py[POS_W-2:0]) / cs;
        if (px[POS_W-1] || py[POS_W-1] || nx >= cx || ny >= cy)
            out_f = 1'b1;
        else
        begin
            mx = int'((longint'(px) * s) / cs) - nx * s;
            my = int'((longint'(py) * s) / cs) - ny * s;
        end
        if (out_f)
        begin
            nx = cx;
            ny = cy;
            mx = s;
            my = s;
        end
        c3 = s + 1;
        c2 = c3 * c3;
        c1 = c2 * (cy + 1);
        ce = int'((c1 * nx + c2 * ny + c3 * s + s) % ENTRIES);
        fe = out_f ? ce : int'((c1 * nx + c2 * ny + c3 * mx + my) % ENTRIES);
        r.ce = ce[ENTRY_W-1:0];
        r.fe = fe[ENTRY_W-1:0];
        r.outside = out_f;
        r.cpred = NO_PRED;
        r.fpred = NO_PRED;
        if (particles_held >= MAX_PARTS)
            r.dropped = 1'b1;
        else
        begin
            r.number = particles_held[NUMBER_W-1:0];
            if (list_tail[ce] >= 0)
                r.cpred = list_tail[ce][PRED_W-1:0];
            list_tail[ce] = particles_held;
            if (!out_f)
            begin
                if (list_tail[fe] >= 0)
                    r.fpred = list_tail[fe][PRED_W-1:0];
                list_tail[fe] = particles_held;
            end
            particles_held++;
        end
        return r;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        bin_t e;
        if (rst_n && done)
        begin
            if (pending_bins.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                e = pending_bins.pop_front();
                check_field("particle_number", e.number, particle_number);
                check_field("coarse_entry", e.ce, coarse_entry);
                check_field("fine_entry", e.fe, fine_entry);
                check_field("outside", e.outside, outside);
                check_field("coarse_pred", signed'(e.cpred), coarse_pred);
                check_field("fine_pred", signed'(e.fpred), fine_pred);
                check_field("dropped", e.dropped, dropped);
            end
        end
    end

    task automatic send_particle(logic rs, logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        @(negedge clk);
        start = 1'b1;
        restart = rs;
        pos_x = x;
        pos_y = y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_bins.insert(pending_bins.size(), bin_particle(rs, x, y));
    endtask

    task automatic pause_sender(int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Holds the sender until every expected beat has come and busy is low.
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_bins.size() != 0)
            @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        drain_results();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value[SIZE_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_CELLS_X:   sh_cells_x = value[CELLS_W-1:0];
            REG_CELLS_Y:   sh_cells_y = value[CELLS_W-1:0];
            REG_SUB_DIV:   sh_sub_div = value[SUB_W-1:0];
            REG_CELL_SIZE: sh_cell_size = value[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_config(int cx, int cy, int s, int cs);
        write_reg(REG_CELLS_X, cx);
        write_reg(REG_CELLS_Y, cy);
        write_reg(REG_SUB_DIV, s);
        write_reg(REG_CELL_SIZE, cs);
    endtask

    // Mostly coordinates near the grid, sometimes any 20-bit pattern.
    function automatic logic [POS_W-1:0] random_coord(int cells);
        longint span;
        span = longint'(cells) * effective_size() + effective_size() / 2;
        if (span > 524287)
            span = 524287;
        if ($urandom_range(0, 9) < 8)
            return POS_W'($urandom_range(0, int'(span)));
        return POS_W'($urandom);
    endfunction

    task automatic test_default_grid();
        send_particle(1'b0, 20'd0, 20'd0);
        send_particle(1'b0, 20'd10, 20'd20);
        send_particle(1'b0, 20'd200, 20'd200);
        send_particle(1'b0, 20'd4095, 20'd4095);
        send_particle(1'b0, 20'd4096, 20'd100);
        send_particle(1'b0, 20'd100, 20'd4096);
        send_particle(1'b0, 20'hFFFFF, 20'd5);
        send_particle(1'b0, 20'd5, 20'h80000);
        send_particle(1'b0, 20'h7FFFF, 20'h7FFFF);
        send_particle(1'b0, 20'h80000, 20'hFFFFF);
        send_particle(1'b0, 20'd128, 20'd384);
        send_particle(1'b0, 20'd129, 20'd385);
        send_particle(1'b1, 20'd129, 20'd385);
        send_particle(1'b0, 20'd129, 20'd385);
    endtask

    task automatic test_config_extremes();
        write_config(1, 1, 1, 1);
        send_particle(1'b0, 20'd0, 20'd0);
        send_particle(1'b0, 20'd0, 20'd0);
        send_particle(1'b0, 20'd1, 20'd0);
        write_config(16, 16, 4, 524287);
        send_particle(1'b0, 20'h7FFFF, 20'd0);
        send_particle(1'b0, 20'd393216, 20'd131071);
        send_particle(1'b0, 20'h7FFFF, 20'h7FFFF);
        // Out-of-range settings saturate, and a zero cell size acts as one.
        write_config(0, 31, 0, 0);
        send_particle(1'b0, 20'd0, 20'd15);
        send_particle(1'b0, 20'd0, 20'd16);
        write_config(31, 0, 7, 3);
        send_particle(1'b0, 20'd47, 20'd2);
        send_particle(1'b0, 20'd50, 20'd0);
        write_config(16, 16, 2, 256);
    endtask

    task automatic test_random_traffic(int total);
        int sent, burst, k, phase;
        sent = 0;
        phase = 0;
        while (sent < total)
        begin
            case (phase % 4)
                0: write_config($urandom_range(1, 16), $urandom_range(1, 16),
                                $urandom_range(1, 4), $urandom_range(1, 600));
                1: write_config($urandom_range(0, 31), $urandom_range(0, 31),
                                $urandom_range(0, 7), $urandom);
                2: write_config(16, 16, 4, $urandom_range(1, 40));
                default: write_config($urandom_range(1, 16), $urandom_range(1, 16),
                                      $urandom_range(1, 4), $urandom_range(1, 32767));
            endcase
            phase++;
            k = 0;
            while (k < 280 && sent < total)
            begin
                burst = $urandom_range(1, 24);
                repeat (burst)
                begin
                    send_particle($urandom_range(0, 149) == 0,
                                  random_coord(effective_cx()),
                                  random_coord(effective_cy()));
                    k++;
                    sent++;
                end
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 30));
            end
        end
    endtask

    initial
    begin
        clear_lists();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_default_grid();
        test_config_extremes();
        test_random_traffic(1626);
        drain_results();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
